@@ src/m3md_pkg.sv @@
`default_nettype none

package m3md_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int DIGIT_BITS = 16;   // multiplier digit width, one digit per cycle
    localparam int ELEMS      = 9;
    localparam int IDX_W      = 4;
    localparam int VALUE_W    = 32;

    localparam logic [1:0] MODE_AB  = 2'd0;
    localparam logic [1:0] MODE_ATB = 2'd1;
    localparam logic [1:0] MODE_ABT = 2'd2;
    localparam logic [1:0] MODE_DET = 2'd3;

    localparam logic [1:0] IDX_MAX = 2'd2;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic [1:0]                mode;
        logic                      matrix_select;
        logic [1:0]                row;
        logic [1:0]                col;
        logic signed [VALUE_W-1:0] value;
        logic                      go;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                out_row;
        logic [1:0]                out_col;
        logic signed [VALUE_W-1:0] result;
        logic                      overflow;
        logic                      last;
    } t_out_item;

    typedef struct packed {
        logic en;
        logic sel;   // 0 writes A, 1 writes B
        t_idx addr;
    } t_store_wr;

    typedef struct packed {
        t_idx a0;
        t_idx a1;
        t_idx b;
    } t_store_rd;

    typedef struct packed {
        t_idx a0;
        t_idx a1;
    } t_det_pair;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_START,
        ST_WAIT,
        ST_EMIT
    } t_state;

    function automatic t_idx idx3(input logic [1:0] r, input logic [1:0] c);
        return t_idx'({r, 1'b0}) + t_idx'(r) + t_idx'(c);
    endfunction

    // Element pairs of the 2x2 minors for cofactor expansion along row 0.
    function automatic t_det_pair det_pair(input logic [1:0] term, input logic second);
        t_det_pair p;
        case (term)
            2'd0:    p = second ? t_det_pair'{t_idx'(5), t_idx'(7)}
                                : t_det_pair'{t_idx'(4), t_idx'(8)};
            2'd1:    p = second ? t_det_pair'{t_idx'(3), t_idx'(8)}
                                : t_det_pair'{t_idx'(5), t_idx'(6)};
            2'd2:    p = second ? t_det_pair'{t_idx'(4), t_idx'(6)}
                                : t_det_pair'{t_idx'(3), t_idx'(7)};
            default: p = t_det_pair'{t_idx'(0), t_idx'(0)};
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

@@ src/m3md_ram.sv @@
`default_nettype none

module m3md_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 9,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/m3md_store.sv @@
`default_nettype none

module m3md_store #(
    parameter int WIDTH = m3md_pkg::WORD_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  m3md_pkg::t_store_wr     i_wr,
    input  logic [WIDTH-1:0]        i_wdata,
    input  m3md_pkg::t_store_rd     i_rd,
    output logic signed [WIDTH-1:0] o_a0,
    output logic signed [WIDTH-1:0] o_a1,
    output logic signed [WIDTH-1:0] o_b
);

    logic [m3md_pkg::ELEMS-1:0] r_a_vld;
    logic [m3md_pkg::ELEMS-1:0] r_b_vld;
    logic                       r_a0_ok;
    logic                       r_a1_ok;
    logic                       r_b_ok;
    logic                       we_a;
    logic                       we_b;
    logic [WIDTH-1:0]           ram_a0;
    logic [WIDTH-1:0]           ram_a1;
    logic [WIDTH-1:0]           ram_b;

    assign we_a = i_wr.en & ~i_wr.sel;
    assign we_b = i_wr.en & i_wr.sel;

    // Entries never written read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= '0;
            r_b_vld <= '0;
            r_a0_ok <= 1'b0;
            r_a1_ok <= 1'b0;
            r_b_ok  <= 1'b0;
        end else begin
            if (we_a) begin
                r_a_vld[i_wr.addr] <= 1'b1;
            end
            if (we_b) begin
                r_b_vld[i_wr.addr] <= 1'b1;
            end
            r_a0_ok <= r_a_vld[i_rd.a0];
            r_a1_ok <= r_a_vld[i_rd.a1];
            r_b_ok  <= r_b_vld[i_rd.b];
        end
    end

    // Matrix A is kept in two copies to get two read ports.
    m3md_ram #(.WIDTH(WIDTH), .DEPTH(m3md_pkg::ELEMS)) u_ram_a0 (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wdata),
        .i_raddr (i_rd.a0),
        .o_rdata (ram_a0)
    );

    m3md_ram #(.WIDTH(WIDTH), .DEPTH(m3md_pkg::ELEMS)) u_ram_a1 (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wdata),
        .i_raddr (i_rd.a1),
        .o_rdata (ram_a1)
    );

    m3md_ram #(.WIDTH(WIDTH), .DEPTH(m3md_pkg::ELEMS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wdata),
        .i_raddr (i_rd.b),
        .o_rdata (ram_b)
    );

    assign o_a0 = r_a0_ok ? $signed(ram_a0) : '0;
    assign o_a1 = r_a1_ok ? $signed(ram_a1) : '0;
    assign o_b  = r_b_ok  ? $signed(ram_b)  : '0;

endmodule

`default_nettype wire

@@ src/m3md_mul.sv @@
`default_nettype none

module m3md_mul #(
    parameter int XW = 65,
    parameter int YW = 32,
    parameter int DW = m3md_pkg::DIGIT_BITS,
    localparam int NDIG = (YW + DW - 1) / DW,
    localparam int YPW = NDIG * DW,
    localparam int PW = XW + YPW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [YW-1:0] i_y,
    output logic                 o_busy,
    output logic                 o_done,
    output logic signed [PW-1:0] o_prod
);

    localparam int CW = $clog2(NDIG + 1);

    logic signed [XW-1:0]   r_x;
    logic [YPW-1:0]         r_y;
    logic signed [PW-1:0]   r_prod;
    logic [CW-1:0]          r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic                   r_first;
    logic [DW-1:0]          digit;
    logic signed [DW:0]     sdig;
    logic signed [XW+DW:0]  pp;
    logic signed [PW-1:0]   n_prod;

    // Digits go most significant first; only the top digit carries the sign.
    assign digit  = r_y[YPW-1 -: DW];
    assign sdig   = {r_first & digit[DW-1], digit};
    assign pp     = r_x * sdig;
    assign n_prod = (r_prod <<< DW) + PW'(pp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_first <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_first <= 1'b1;
                r_cnt   <= CW'(NDIG);
            end else if (r_busy) begin
                r_first <= 1'b0;
                r_cnt   <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_x;
            r_y    <= YPW'(i_y);
            r_prod <= '0;
        end else if (r_busy) begin
            r_y    <= r_y << DW;
            r_prod <= n_prod;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ src/matrix3_multiply_determinant.sv @@
`default_nettype none

// 3x3 fixed-point matrix multiply and determinant. Load items write one element of A or B
// (row-major, out-of-range row or column is dropped) and are taken back to back while idle;
// both matrices read as zero after reset until written. A go item runs A*B, A'*B, A*B' or
// det(A) and blocks further input until its last result has gone into the output register.
// Each multiply reads the element stores through their registered RAM read, starts the
// digit-serial multiplier, which works through ceil(WORD_WIDTH/16) digits, and takes the
// product. A product element takes three multiplies and the determinant nine; the result
// then waits in the emit state while the output register holds an item not yet taken.
// Results are truncated toward minus infinity and saturated to WORD_WIDTH bits; overflow
// flags saturation. No clearing pass is needed after reset.

module matrix3_multiply_determinant #(
    parameter int WORD_WIDTH = m3md_pkg::WORD_WIDTH,
    parameter int FRAC_BITS  = m3md_pkg::FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  m3md_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output m3md_pkg::t_out_item o_out_item
);

    localparam int W    = WORD_WIDTH;
    localparam int XW   = 2 * W + 1;            // 2x2 minor
    localparam int AW   = 3 * W + 3;            // dot product / determinant sum
    localparam int DW   = m3md_pkg::DIGIT_BITS;
    localparam int NDIG = (W + DW - 1) / DW;
    localparam int PW   = XW + NDIG * DW;
    localparam int RW   = m3md_pkg::VALUE_W;

    // determinant phases within one cofactor term
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_COF    = 2'd2;

    m3md_pkg::t_state     r_state;
    m3md_pkg::t_state     n_state;
    logic [1:0]           r_mode;
    logic [1:0]           n_mode;
    logic [1:0]           r_i;
    logic [1:0]           n_i;
    logic [1:0]           r_j;
    logic [1:0]           n_j;
    logic [1:0]           r_k;
    logic [1:0]           n_k;
    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] n_acc;
    logic signed [XW-1:0] r_cross;
    logic signed [XW-1:0] n_cross;
    logic                 r_out_valid;
    logic                 n_out_valid;
    m3md_pkg::t_out_item  r_out;
    m3md_pkg::t_out_item  n_out;

    logic                 in_accept;
    logic                 is_det;
    m3md_pkg::t_store_wr  wr;
    m3md_pkg::t_store_rd  rd;
    m3md_pkg::t_det_pair  pair;
    logic signed [W-1:0]  st_a0;
    logic signed [W-1:0]  st_a1;
    logic signed [W-1:0]  st_b;

    logic                 mul_start;
    logic                 mul_busy;
    logic                 mul_done;
    logic signed [XW-1:0] mul_x;
    logic signed [W-1:0]  mul_y;
    logic signed [PW-1:0] mul_prod;

    logic signed [AW-1:0] shifted;
    logic [AW-W:0]        hi;
    logic                 fits;
    logic [W-1:0]         sat_word;
    logic                 last_elem;

    assign is_det     = (r_mode == m3md_pkg::MODE_DET);
    assign o_in_ready = (r_state == m3md_pkg::ST_IDLE);
    assign in_accept  = i_in_valid & o_in_ready;

    // Loads write straight from the input item.
    assign wr.en   = in_accept & ~i_in_item.go
                   & (i_in_item.row <= m3md_pkg::IDX_MAX)
                   & (i_in_item.col <= m3md_pkg::IDX_MAX);
    assign wr.sel  = i_in_item.matrix_select;
    assign wr.addr = m3md_pkg::idx3(i_in_item.row, i_in_item.col);

    always_comb begin
        pair = m3md_pkg::det_pair(r_i, r_k[0]);
        if (is_det) begin
            rd.a0 = (r_k == PH_COF) ? m3md_pkg::t_idx'(r_i) : pair.a0;
            rd.a1 = pair.a1;
            rd.b  = '0;
        end else begin
            rd.a0 = (r_mode == m3md_pkg::MODE_ATB) ? m3md_pkg::idx3(r_k, r_i)
                                                   : m3md_pkg::idx3(r_i, r_k);
            rd.a1 = '0;
            rd.b  = (r_mode == m3md_pkg::MODE_ABT) ? m3md_pkg::idx3(r_j, r_k)
                                                   : m3md_pkg::idx3(r_k, r_j);
        end
    end

    m3md_store #(.WIDTH(W)) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_wdata (W'(i_in_item.value)),
        .i_rd    (rd),
        .o_a0    (st_a0),
        .o_a1    (st_a1),
        .o_b     (st_b)
    );

    // Cofactor phase multiplies the stored minor by the row-0 element.
    assign mul_x = (is_det && r_k == PH_COF) ? r_cross : XW'(st_a0);
    assign mul_y = is_det ? ((r_k == PH_COF) ? st_a0 : st_a1) : st_b;

    m3md_mul #(.XW(XW), .YW(W), .DW(DW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .o_busy  (mul_busy),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // Truncate and saturate.
    always_comb begin
        shifted  = is_det ? (r_acc >>> (2 * FRAC_BITS)) : (r_acc >>> FRAC_BITS);
        hi       = shifted[AW-1:W-1];
        fits     = (&hi) | ~(|hi);
        if (fits) begin
            sat_word = shifted[W-1:0];
        end else if (shifted[AW-1]) begin
            sat_word = {1'b1, {(W-1){1'b0}}};
        end else begin
            sat_word = {1'b0, {(W-1){1'b1}}};
        end
    end

    assign last_elem = is_det | ((r_i == m3md_pkg::IDX_MAX) & (r_j == m3md_pkg::IDX_MAX));

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_acc       = r_acc;
        n_cross     = r_cross;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_out       = r_out;
        mul_start   = 1'b0;
        case (r_state)
            m3md_pkg::ST_IDLE: begin
                if (in_accept && i_in_item.go) begin
                    n_mode  = i_in_item.mode;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                    n_acc   = '0;
                    n_state = m3md_pkg::ST_READ;
                end
            end
            m3md_pkg::ST_READ: begin
                n_state = m3md_pkg::ST_START;
            end
            m3md_pkg::ST_START: begin
                mul_start = 1'b1;
                n_state   = m3md_pkg::ST_WAIT;
            end
            m3md_pkg::ST_WAIT: begin
                if (mul_done) begin
                    if (is_det && r_k == PH_FIRST) begin
                        n_cross = XW'(mul_prod);
                    end else if (is_det && r_k == PH_SECOND) begin
                        n_cross = r_cross - XW'(mul_prod);
                    end else begin
                        n_acc = r_acc + AW'(mul_prod);
                    end
                    if (r_k != m3md_pkg::IDX_MAX) begin
                        n_k     = r_k + 2'd1;
                        n_state = m3md_pkg::ST_READ;
                    end else if (is_det && r_i != m3md_pkg::IDX_MAX) begin
                        n_i     = r_i + 2'd1;
                        n_k     = '0;
                        n_state = m3md_pkg::ST_READ;
                    end else begin
                        n_state = m3md_pkg::ST_EMIT;
                    end
                end
            end
            m3md_pkg::ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid    = 1'b1;
                    n_out.out_row  = is_det ? 2'd0 : r_i;
                    n_out.out_col  = is_det ? 2'd0 : r_j;
                    n_out.result   = RW'(sat_word);
                    n_out.overflow = ~fits;
                    n_out.last     = last_elem;
                    n_acc          = '0;
                    n_k            = '0;
                    if (last_elem) begin
                        n_state = m3md_pkg::ST_IDLE;
                    end else begin
                        n_state = m3md_pkg::ST_READ;
                        if (r_j == m3md_pkg::IDX_MAX) begin
                            n_j = '0;
                            n_i = r_i + 2'd1;
                        end else begin
                            n_j = r_j + 2'd1;
                        end
                    end
                end
            end
            default: begin
                n_state = m3md_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= m3md_pkg::ST_IDLE;
            r_mode      <= m3md_pkg::MODE_AB;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_cross <= n_cross;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_mul_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> !mul_busy)
        else $error("multiplier started while busy");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == m3md_pkg::ST_WAIT))
        else $error("product ready outside wait state");

    a_go_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_item.go) |=> !o_in_ready)
        else $error("input taken during a run");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_i <= m3md_pkg::IDX_MAX) && (r_j <= m3md_pkg::IDX_MAX)
        && (r_k <= m3md_pkg::IDX_MAX))
        else $error("element counter out of range");

endmodule

`default_nettype wire
